[hw/rtl/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

[hw/rtl/ctt_pkg.sv]
`timescale 1ns / 1ps

package ctt_pkg;

    localparam int LINE_BITS_DEF = 24;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_LITERAL,
        MODE_SLASH,
        MODE_LINE_CMT,
        MODE_BLOCK,
        MODE_BLOCK_STAR
    } t_mode;

    localparam logic [2:0] KIND_EQUALS  = 3'd0;
    localparam logic [2:0] KIND_COLON   = 3'd1;
    localparam logic [2:0] KIND_OPEN    = 3'd2;
    localparam logic [2:0] KIND_CLOSE   = 3'd3;
    localparam logic [2:0] KIND_IDENT   = 3'd4;
    localparam logic [2:0] KIND_LITERAL = 3'd5;
    localparam logic [2:0] KIND_INVALID = 3'd6;
    localparam logic [2:0] KIND_UNTERM  = 3'd7;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_OPEN  = 8'h7B;
    localparam logic [7:0] CH_CLOSE = 8'h7D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;

    function automatic logic is_ident(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER || c == CH_DASH;
    endfunction

endpackage

[hw/rtl/config_text_tokenizer.sv]
`timescale 1ns / 1ps
// Streaming tokenizer for a small configuration text format.
// Input channel (s_axis): one text byte per beat in tdata, tuser set marks
// end of text (byte ignored). Output channel (m_axis): one token event per
// beat; tuser carries kind, token start and has-char flags, tdata carries
// the appended character and the line of a token start, tlast marks the
// final event caused by one input beat.
// Each accepted byte is scanned in the cycle it is accepted; its events
// (none to three) are stored as one bundle in a two-entry bundle queue and
// appear on m_axis from there, one per cycle while the receiver is ready.
// A byte causing at most one event can be taken every cycle while m_axis is
// ready; one causing more holds the output for one beat per event, so the
// output rate sets the sustained rate when colons or lone slashes are frequent.
// s_axis_tready drops only when both bundle entries are occupied, so one
// byte is still taken while a finished event waits on a stalled receiver.
// Synchronous active-low reset empties the queue, returns the scanner to
// idle and sets the line counter to one; end of text does the same to the
// scanner state after its final events.
module config_text_tokenizer
    import ctt_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [7:0]                            s_axis_tdata,  // char_code
    input  logic [0:0]                            s_axis_tuser,  // end_of_text
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // char_out, token_line, zero fill
    output logic [((8 + LINE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // token_kind, starts_token, has_char
    output logic [4:0]                            m_axis_tuser,
    output logic                                  m_axis_tlast   // last_of_item
);

    localparam int OUT_DW = ((8 + LINE_BITS + 7) / 8) * 8;
    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    typedef struct packed {
        logic [2:0]           kind;
        logic                 start;
        logic                 has;
        logic [7:0]           ch;
        logic [LINE_BITS-1:0] line;
    } t_res;

    typedef struct packed {
        logic [1:0] cnt;
        t_res [2:0] res;
    } t_bundle;

    function automatic t_res mk_res(input logic [2:0] kind, input logic start,
                                    input logic has, input logic [7:0] ch,
                                    input logic [LINE_BITS-1:0] line);
        t_res r;
        r.kind  = kind;
        r.start = start;
        r.has   = has;
        r.ch    = ch;
        r.line  = line;
        return r;
    endfunction

    // scanner state
    t_mode                r_mode, n_mode;
    logic [LINE_BITS-1:0] r_line, n_line;
    logic [LINE_BITS-1:0] r_cline, n_cline;
    logic                 r_linv, n_linv;
    logic                 r_llit, n_llit;
    logic                 r_held, n_held;

    // bundle queue
    t_bundle    r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [1:0] r_idx;

    t_bundle n_bundle;
    logic    in_fire, push, pop;
    t_res    head_res;

    assign s_axis_tready = (r_cnt != 2'd2);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign push          = in_fire && (n_bundle.cnt != 2'd0);

    always_comb begin
        logic [7:0] c;
        logic [1:0] k;
        logic       do_idle;
        c        = s_axis_tdata;
        k        = 2'd0;
        do_idle  = 1'b0;
        n_mode   = r_mode;
        n_line   = r_line;
        n_cline  = r_cline;
        n_linv   = r_linv;
        n_llit   = r_llit;
        n_held   = r_held;
        n_bundle = '0;

        if (s_axis_tuser[0]) begin
            if (r_mode == MODE_SLASH) begin
                n_bundle.res[k] = mk_res(KIND_INVALID, 1'b1, 1'b1, CH_SLASH, r_line);
                k = k + 2'd1;
            end else if (r_mode == MODE_BLOCK || r_mode == MODE_BLOCK_STAR) begin
                n_bundle.res[k] = mk_res(KIND_UNTERM, 1'b1, 1'b0, 8'd0, r_cline);
                k = k + 2'd1;
            end
            n_mode  = MODE_IDLE;
            n_line  = LINE_ONE;
            n_cline = LINE_ONE;
            n_linv  = 1'b0;
            n_llit  = 1'b0;
            n_held  = 1'b0;
        end else begin
            unique case (r_mode)
                MODE_IDENT: begin
                    if (is_ident(c)) begin
                        n_bundle.res[k] = mk_res(KIND_IDENT, 1'b0, 1'b1, c, '0);
                        k = k + 2'd1;
                    end else begin
                        do_idle = 1'b1;
                    end
                end
                MODE_LITERAL: begin
                    if (c == CH_NL) begin
                        if (n_line != LINE_MAX) n_line = n_line + LINE_ONE;
                        n_held = 1'b1;
                        n_mode = MODE_IDLE;
                    end else begin
                        n_bundle.res[k] = mk_res(KIND_LITERAL, 1'b0, 1'b1, c, '0);
                        k = k + 2'd1;
                    end
                end
                MODE_SLASH: begin
                    if (c == CH_SLASH) begin
                        n_mode = MODE_LINE_CMT;
                    end else if (c == CH_STAR) begin
                        n_cline = r_line;
                        n_mode  = MODE_BLOCK;
                    end else begin
                        // lone slash opens its own invalid token, then the byte is rescanned
                        n_bundle.res[k] = mk_res(KIND_INVALID, 1'b1, 1'b1, CH_SLASH, r_line);
                        k = k + 2'd1;
                        n_linv  = 1'b1;
                        n_llit  = 1'b0;
                        n_held  = 1'b0;
                        do_idle = 1'b1;
                    end
                end
                MODE_LINE_CMT: begin
                    if (c == CH_NL) begin
                        if (n_line != LINE_MAX) n_line = n_line + LINE_ONE;
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_BLOCK, MODE_BLOCK_STAR: begin
                    if (r_mode == MODE_BLOCK_STAR && c == CH_SLASH) begin
                        n_mode = MODE_IDLE;
                    end else if (c == CH_STAR) begin
                        n_mode = MODE_BLOCK_STAR;
                    end else begin
                        if (c == CH_NL && n_line != LINE_MAX) n_line = n_line + LINE_ONE;
                        n_mode = MODE_BLOCK;
                    end
                end
                default: begin
                    do_idle = 1'b1;
                end
            endcase

            if (do_idle) begin
                n_mode = MODE_IDLE;
                if (c == CH_SPACE || c == CH_TAB) begin
                    n_mode = MODE_IDLE;
                end else if (c == CH_NL) begin
                    if (n_line != LINE_MAX) n_line = n_line + LINE_ONE;
                end else if (c == CH_SLASH) begin
                    n_mode = MODE_SLASH;
                end else if (c == CH_COLON) begin
                    if (n_llit) begin
                        // continue the literal, restoring the withheld newline
                        if (n_held) begin
                            n_bundle.res[k] = mk_res(KIND_LITERAL, 1'b0, 1'b1, CH_NL, '0);
                            k = k + 2'd1;
                        end
                        n_held = 1'b0;
                    end else begin
                        n_bundle.res[k] = mk_res(KIND_COLON, 1'b1, 1'b1, CH_COLON, n_line);
                        k = k + 2'd1;
                        n_bundle.res[k] = mk_res(KIND_LITERAL, 1'b1, 1'b0, 8'd0, n_line);
                        k = k + 2'd1;
                        n_linv = 1'b0;
                        n_llit = 1'b1;
                        n_held = 1'b0;
                    end
                    n_mode = MODE_LITERAL;
                end else if (c == CH_EQ || c == CH_OPEN || c == CH_CLOSE || is_ident(c)) begin
                    if (c == CH_EQ)
                        n_bundle.res[k] = mk_res(KIND_EQUALS, 1'b1, 1'b1, c, n_line);
                    else if (c == CH_OPEN)
                        n_bundle.res[k] = mk_res(KIND_OPEN, 1'b1, 1'b1, c, n_line);
                    else if (c == CH_CLOSE)
                        n_bundle.res[k] = mk_res(KIND_CLOSE, 1'b1, 1'b1, c, n_line);
                    else begin
                        n_bundle.res[k] = mk_res(KIND_IDENT, 1'b1, 1'b1, c, n_line);
                        n_mode = MODE_IDENT;
                    end
                    k = k + 2'd1;
                    n_linv = 1'b0;
                    n_llit = 1'b0;
                    n_held = 1'b0;
                end else begin
                    if (n_linv)
                        n_bundle.res[k] = mk_res(KIND_INVALID, 1'b0, 1'b1, c, '0);
                    else
                        n_bundle.res[k] = mk_res(KIND_INVALID, 1'b1, 1'b1, c, n_line);
                    k = k + 2'd1;
                    n_linv = 1'b1;
                    n_llit = 1'b0;
                    n_held = 1'b0;
                end
            end
        end
        n_bundle.cnt = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_line  <= LINE_ONE;
            r_cline <= LINE_ONE;
            r_linv  <= 1'b0;
            r_llit  <= 1'b0;
            r_held  <= 1'b0;
        end else if (in_fire) begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_cline <= n_cline;
            r_linv  <= n_linv;
            r_llit  <= n_llit;
            r_held  <= n_held;
        end
    end

    // output side: walk the head bundle one beat at a time
    assign head_res      = r_q[r_rp].res[r_idx];
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tlast  = (r_idx == r_q[r_rp].cnt - 2'd1);
    assign m_axis_tuser  = {head_res.has, head_res.start, head_res.kind};
    assign m_axis_tdata  = OUT_DW'({head_res.line, head_res.ch});
    assign pop           = m_axis_tvalid && m_axis_tready && m_axis_tlast;

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) begin
                r_rp  <= ~r_rp;
                r_idx <= 2'd0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_idx <= r_idx + 2'd1;
            end
            if (push && !pop)
                r_cnt <= r_cnt + 2'd1;
            else if (pop && !push)
                r_cnt <= r_cnt - 2'd1;
        end
    end

endmodule

[hw/rtl/ctt_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ctt_checker
    import ctt_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF
) (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  s_axis_tready,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [((8 + LINE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input logic [4:0]                            m_axis_tuser,
    input logic                                  m_axis_tlast
);

    logic [LINE_BITS-1:0] beat_line;
    logic [7:0]           beat_char;

    assign beat_char = m_axis_tdata[7:0];
    assign beat_line = m_axis_tdata[8 +: LINE_BITS];

    // a stalled beat keeps its payload
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // input is only held off while events are waiting downstream
    `ASSERT_IMPL(a_backpressure, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid)

    // a continuing beat carries no line and a charless beat no character
    `ASSERT_IMPL(a_line_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[3],
        beat_line == '0)
    `ASSERT_IMPL(a_char_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[4],
        beat_char == 8'd0)

    // unterminated comment always opens a charless token on a real line
    `ASSERT_IMPL(a_unterm, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[2:0] == KIND_UNTERM,
        m_axis_tuser[3] && !m_axis_tuser[4] && beat_line != '0 && m_axis_tlast)

endmodule

bind config_text_tokenizer ctt_checker #(.LINE_BITS(LINE_BITS)) u_ctt_checker (.*);

[verif/tb_config_text_tokenizer.sv]
`timescale 1ns / 1ps

module tb_config_text_tokenizer;
    import ctt_pkg::*;

    localparam int LINE_W   = LINE_BITS_DEF;
    localparam int TDATA_W  = ((8 + LINE_W + 7) / 8) * 8;
    localparam int LINE_TOP = (1 << LINE_W) - 1;

    typedef struct {
        logic [2:0]        kind;
        logic              starts;
        logic              has;
        logic [7:0]        ch;
        logic [LINE_W-1:0] line;
        logic              last;
    } t_tok_event;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic [7:0]         s_tdata = '0;
    logic [0:0]         s_tuser = '0;
    logic               m_tready = 1'b0;
    wire                s_axis_tready;
    wire                m_axis_tvalid;
    wire  [TDATA_W-1:0] m_axis_tdata;   // char_out, token_line
    wire  [4:0]         m_axis_tuser;   // token_kind, starts_token, has_char
    wire                m_axis_tlast;   // last_of_item

    config_text_tokenizer #(
        .LINE_BITS(LINE_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_tdata),    // char_code
        .s_axis_tuser(s_tuser),    // end_of_text
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    // scanner mirror
    t_mode             scan_st = MODE_IDLE;
    logic [LINE_W-1:0] line_no = 1;
    logic [LINE_W-1:0] comment_line = 1;
    bit                prev_invalid = 1'b0;
    bit                prev_literal = 1'b0;
    bit                nl_pending = 1'b0;

    t_tok_event events_due[$];
    t_tok_event step_events[$];

    int n_fail = 0;
    int n_sent = 0;
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int rx_gap = 0;
    int rx_hold = 0;
    int rx_hold_req = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic bit is_word_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == CH_UNDER || c == CH_DASH;
    endfunction

    function automatic void add_event(input logic [2:0] kind, input logic starts,
                                      input logic has, input logic [7:0] ch,
                                      input logic [LINE_W-1:0] line);
        t_tok_event ev;
        ev = '{kind, starts, has, ch, line, 1'b0};
        step_events = {step_events, ev};
    endfunction

    function automatic void bump_line();
        if (line_no != LINE_W'(LINE_TOP))
            line_no++;
    endfunction

    function automatic void single_token(input logic [2:0] kind, input logic [7:0] c);
        add_event(kind, 1'b1, 1'b1, c, line_no);
        prev_invalid = 1'b0;
        prev_literal = 1'b0;
        nl_pending = 1'b0;
    endfunction

    // a slash that opened no comment is always a fresh invalid token
    function automatic void slash_token();
        add_event(KIND_INVALID, 1'b1, 1'b1, CH_SLASH, line_no);
        prev_invalid = 1'b1;
        prev_literal = 1'b0;
        nl_pending = 1'b0;
    endfunction

    function automatic void restart_text();
        scan_st = MODE_IDLE;
        line_no = 1;
        comment_line = 1;
        prev_invalid = 1'b0;
        prev_literal = 1'b0;
        nl_pending = 1'b0;
    endfunction

    function automatic void scan_between(input logic [7:0] c);
        scan_st = MODE_IDLE;
        if (c == CH_SPACE || c == CH_TAB) begin
            return;
        end
        if (c == CH_NL) begin
            bump_line();
        end else if (c == CH_SLASH) begin
            scan_st = MODE_SLASH;
        end else if (c == CH_EQ) begin
            single_token(KIND_EQUALS, c);
        end else if (c == CH_COLON) begin
            // colon after a literal carries it on, with the withheld newline
            if (prev_literal) begin
                if (nl_pending)
                    add_event(KIND_LITERAL, 1'b0, 1'b1, CH_NL, '0);
                nl_pending = 1'b0;
            end else begin
                add_event(KIND_COLON, 1'b1, 1'b1, CH_COLON, line_no);
                add_event(KIND_LITERAL, 1'b1, 1'b0, '0, line_no);
                prev_invalid = 1'b0;
                prev_literal = 1'b1;
                nl_pending = 1'b0;
            end
            scan_st = MODE_LITERAL;
        end else if (c == CH_OPEN) begin
            single_token(KIND_OPEN, c);
        end else if (c == CH_CLOSE) begin
            single_token(KIND_CLOSE, c);
        end else if (is_word_char(c)) begin
            single_token(KIND_IDENT, c);
            scan_st = MODE_IDENT;
        end else begin
            if (prev_invalid)
                add_event(KIND_INVALID, 1'b0, 1'b1, c, '0);
            else
                add_event(KIND_INVALID, 1'b1, 1'b1, c, line_no);
            prev_invalid = 1'b1;
            prev_literal = 1'b0;
            nl_pending = 1'b0;
        end
    endfunction

    function automatic void predict_events(input logic [7:0] c, input logic eot);
        step_events.delete();
        if (eot) begin
            if (scan_st == MODE_SLASH)
                slash_token();
            else if (scan_st == MODE_BLOCK || scan_st == MODE_BLOCK_STAR)
                add_event(KIND_UNTERM, 1'b1, 1'b0, '0, comment_line);
            restart_text();
        end else begin
            case (scan_st)
                MODE_IDENT: begin
                    if (is_word_char(c))
                        add_event(KIND_IDENT, 1'b0, 1'b1, c, '0);
                    else
                        scan_between(c);
                end
                MODE_LITERAL: begin
                    if (c == CH_NL) begin
                        bump_line();
                        nl_pending = 1'b1;
                        scan_st = MODE_IDLE;
                    end else begin
                        add_event(KIND_LITERAL, 1'b0, 1'b1, c, '0);
                    end
                end
                MODE_SLASH: begin
                    if (c == CH_SLASH) begin
                        scan_st = MODE_LINE_CMT;
                    end else if (c == CH_STAR) begin
                        comment_line = line_no;
                        scan_st = MODE_BLOCK;
                    end else begin
                        slash_token();
                        scan_between(c);
                    end
                end
                MODE_LINE_CMT: begin
                    if (c == CH_NL) begin
                        bump_line();
                        scan_st = MODE_IDLE;
                    end
                end
                MODE_BLOCK, MODE_BLOCK_STAR: begin
                    if (scan_st == MODE_BLOCK_STAR && c == CH_SLASH) begin
                        scan_st = MODE_IDLE;
                    end else if (c == CH_STAR) begin
                        scan_st = MODE_BLOCK_STAR;
                    end else begin
                        if (c == CH_NL)
                            bump_line();
                        scan_st = MODE_BLOCK;
                    end
                end
                default: scan_between(c);
            endcase
        end
        if (step_events.size() > 0)
            step_events[step_events.size() - 1].last = 1'b1;
        events_due = {events_due, step_events};
    endfunction

    function automatic void cmp_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_fail++;
        end
    endfunction

    function automatic void check_event();
        t_tok_event want;
        if (events_due.size() == 0) begin
            $error("token event (tuser 0x%0h, tdata 0x%0h) with nothing expected",
                   m_axis_tuser, m_axis_tdata);
            n_fail++;
            return;
        end
        want = events_due.pop_front();
        cmp_field("token_kind", want.kind, m_axis_tuser[2:0]);
        cmp_field("starts_token", want.starts, m_axis_tuser[3]);
        cmp_field("has_char", want.has, m_axis_tuser[4]);
        cmp_field("char_out", want.ch, m_axis_tdata[7:0]);
        cmp_field("token_line", want.line, m_axis_tdata[8 +: LINE_W]);
        cmp_field("last_of_item", want.last, m_axis_tlast);
    endfunction

    // receiver: random gaps after each beat when rx_idle is set, plus an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tready && m_axis_tvalid) begin
                check_event();
                rx_gap = rx_idle ? $urandom_range(0, 7) : 0;
            end
            if (rx_hold_req != 0) begin
                rx_hold = rx_hold_req;
                rx_hold_req = 0;
            end
            if (rx_hold != 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // leaves tvalid high on return; the next call drops it before its own gap, stop_sending at the end
    task automatic send_item(input logic [7:0] c, input logic eot);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tuser <= eot;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_events(c, eot);
        n_sent++;
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_item(s[k], 1'b0);
    endtask

    task automatic wait_drained();
        while (events_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        // identifier, equals, colon and literal, literal carry-on and a held newline dropped at end of text
        send_text("a-Z_9=:\n:v\n");
        send_item(8'hFF, 1'b1);
        // closed comment, lone slashes joined by other bytes, slash before colon, open comment and slash at end of text
        send_text("/*\n*/{}/");
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_text("/:\n/*");
        send_item(8'h00, 1'b1);
        send_text("/");
        send_item(8'h00, 1'b1);
    endtask

    task automatic send_segment();
        logic [7:0] c;
        case ($urandom_range(0, 14))
            0, 1: begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 4))
                        0: c = "a" + 8'($urandom_range(0, 25));
                        1: c = "A" + 8'($urandom_range(0, 25));
                        2: c = "0" + 8'($urandom_range(0, 9));
                        3: c = CH_UNDER;
                        default: c = CH_DASH;
                    endcase
                    send_item(c, 1'b0);
                end
            end
            2: send_item(CH_EQ, 1'b0);
            3: send_item(CH_OPEN, 1'b0);
            4: send_item(CH_CLOSE, 1'b0);
            5, 6: begin
                send_item(CH_COLON, 1'b0);
                repeat ($urandom_range(0, 5)) send_item(8'($urandom_range(32, 126)), 1'b0);
                send_item(CH_NL, 1'b0);
            end
            7: send_item(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB, 1'b0);
            8: send_item(CH_NL, 1'b0);
            9: begin
                send_item(CH_SLASH, 1'b0);
                send_item(CH_SLASH, 1'b0);
                repeat ($urandom_range(0, 4)) send_item(8'($urandom_range(0, 255)), 1'b0);
                send_item(CH_NL, 1'b0);
            end
            10: begin
                send_item(CH_SLASH, 1'b0);
                send_item(CH_STAR, 1'b0);
                repeat ($urandom_range(0, 5)) begin
                    case ($urandom_range(0, 3))
                        0: c = CH_STAR;
                        1: c = CH_SLASH;
                        2: c = CH_NL;
                        default: c = 8'($urandom_range(0, 255));
                    endcase
                    send_item(c, 1'b0);
                end
                // now and then left open until end of text
                if ($urandom_range(0, 3) != 0) begin
                    send_item(CH_STAR, 1'b0);
                    send_item(CH_SLASH, 1'b0);
                end
            end
            11: send_item(CH_SLASH, 1'b0);
            12, 13: send_item(8'($urandom_range(0, 255)), 1'b0);
            default: send_item(CH_COLON, 1'b0);
        endcase
    endtask

    task automatic test_random_texts(input int n_items);
        int stop_at;
        stop_at = n_sent + n_items;
        while (n_sent < stop_at) begin
            tx_idle = ($urandom_range(0, 2) != 0);
            rx_idle = ($urandom_range(0, 2) != 0);
            repeat ($urandom_range(2, 10)) send_segment();
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic test_backpressure();
        // receiver blocked long enough for the bundle queue to fill
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        rx_hold_req = 150;
        send_text("={}=a/:x\n:y\n={}/q={}:ab\n}{=");
        stop_sending();
        wait_drained();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_text(":z\n:w");
        send_item(8'h00, 1'b1);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_texts(150);
        test_backpressure();
        stop_sending();
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/ctt_pkg.sv
hw/rtl/config_text_tokenizer.sv
hw/rtl/ctt_checker.sv
verif/tb_config_text_tokenizer.sv
